[hdl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: action and status codes,
// cell operations and the control word that is broadcast along the cell row.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Default number of entries.
  localparam int DEPTH_DEF = 8;

  // Field widths fixed by the item formats.
  localparam int ACT_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 3;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 4;

  // Number of positions the position field can address.
  localparam int POS_N = 1 << POS_W;

  // Action codes carried by an input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_REAR  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_MODIFY     = 3'd4
  } cdq_action_t;

  // Status codes returned with every result item.
  typedef logic [ST_W-1:0] cdq_status_t;
  localparam cdq_status_t ST_OK    = 2'd0;
  localparam cdq_status_t ST_FULL  = 2'd1;
  localparam cdq_status_t ST_EMPTY = 2'd2;
  localparam cdq_status_t ST_RANGE = 2'd3;

  // Operation applied by every cell of the row.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH_REAR,
    OP_PUSH_FRONT,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_MODIFY
  } cdq_op_t;

  // Control word broadcast to the whole row.
  typedef struct packed {
    cdq_op_t                  op;
    logic signed [DATA_W-1:0] value;
  } cdq_ctrl_t;

endpackage

[hdl/cdq_if.sv]
// ----------------------------------------------------------------------------
// cdq_in_if / cdq_out_if
// Valid/ready channels for deque input items and result items.
// ----------------------------------------------------------------------------
interface cdq_in_if
  import cdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, action, item_value, position, input ready);
  modport sink   (input valid, action, item_value, position, output ready);
endinterface

interface cdq_out_if
  import cdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [DATA_W-1:0] popped_value;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, popped_value, occupancy, input ready);
  modport sink   (input valid, status, popped_value, occupancy, output ready);
endinterface

[hdl/cdq_cell.sv]
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque row. Cell i holds the entry i places behind the
// front; pushes and pops at the front shift the whole row by one cell.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cdq_ctrl_t                ctrl,
  input  logic                     mod_sel,
  input  logic                     left_valid,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     right_valid,
  input  logic signed [DATA_W-1:0] right_data,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     rear_o
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // Next contents of this slot for the broadcast operation.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    case (ctrl.op)
      OP_PUSH_FRONT: begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
      end
      OP_POP_FRONT: begin
        valid_nxt = right_valid;
        data_nxt  = right_data;
      end
      OP_PUSH_REAR: begin
        // The first empty slot takes the new entry.
        if (!valid_r && left_valid) begin
          valid_nxt = 1'b1;
          data_nxt  = ctrl.value;
        end
      end
      OP_POP_REAR: begin
        if (rear_o) begin
          valid_nxt = 1'b0;
        end
      end
      OP_MODIFY: begin
        if (mod_sel) begin
          data_nxt = ctrl.value;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag is reset; the entry itself is only read while held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
  assign rear_o  = valid_r && !right_valid;

endmodule

[hdl/circular_deque_top.sv]
// A result item is registered and valid in the cycle after its input is taken.
// Throughput: one item per cycle; an item is taken whenever the result
// register is empty or is being read in the same cycle.
// Each item is applied by the whole row of DEPTH cells together.
// Reset (synchronous, active low) empties the deque and the result register.
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue of DEPTH entries built as a row of shifting cells, with
// push and pop at both ends and in-place overwrite by offset from the front.
// ----------------------------------------------------------------------------
module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_rear;
  logic [DEPTH-1:0]         mod_sel;
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  cdq_ctrl_t                ctrl;
  cdq_status_t              status_nxt;
  logic signed [DATA_W-1:0] popped_nxt;
  logic signed [DATA_W-1:0] rear_data;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     in_accept;
  logic                     is_full;
  logic                     is_empty;
  logic                     pos_held;

  logic                     out_valid_r;
  cdq_status_t              status_r;
  logic signed [DATA_W-1:0] popped_r;
  logic [OCC_W-1:0]         occ_r;

  // Input is taken whenever the result register is free or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign is_full  = cell_valid[DEPTH-1];
  assign is_empty = !cell_valid[0];
  assign pos_held = |(mod_sel & cell_valid);

  // Offset decode for modify; only the first POS_N cells can be addressed.
  for (genvar i = 0; i < DEPTH; i++) begin : g_sel
    if (i < POS_N) begin : g_addr
      assign mod_sel[i] = (in_ch.position == POS_W'(i));
    end else begin : g_none
      assign mod_sel[i] = 1'b0;
    end
  end

  // The rear cell is the only one flagged; gather its entry.
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | (cell_data[i] & {DATA_W{cell_rear[i]}});
    end
  end

  // Decode the action into a row operation, status and popped value.
  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.value = in_ch.item_value;
    status_nxt = ST_OK;
    popped_nxt = '0;
    count_nxt  = count_r;
    case (in_ch.action)
      ACT_PUSH_REAR: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op   = OP_PUSH_REAR;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.op   = OP_PUSH_FRONT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.op    = OP_POP_FRONT;
          popped_nxt = cell_data[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      ACT_POP_REAR: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.op    = OP_POP_REAR;
          popped_nxt = rear_data;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      ACT_MODIFY: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else if (!pos_held) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.op = OP_MODIFY;
        end
      end
      default: begin
      end
    endcase
    if (!in_accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  // The row of cells; the front cell takes a front push from the input.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     lv;
    logic signed [DATA_W-1:0] ld;
    logic                     rv;
    logic signed [DATA_W-1:0] rd;

    if (i == 0) begin : g_front
      assign lv = 1'b1;
      assign ld = in_ch.item_value;
    end else begin : g_inner_l
      assign lv = cell_valid[i-1];
      assign ld = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_inner_r
      assign rv = cell_valid[i+1];
      assign rd = cell_data[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .mod_sel     (mod_sel[i]),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid_o     (cell_valid[i]),
      .data_o      (cell_data[i]),
      .rear_o      (cell_rear[i])
    );
  end

  // Entry count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.occupancy    = occ_r;

`ifndef NO_ASSERTIONS
  // The count always matches the number of held cells.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(cell_valid)))
    else $error("entry count differs from held cells");

  // Held cells form one contiguous run from the front: at most one rear.
  a_one_rear: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_rear))
    else $error("more than one rear cell");

  // Rejected items carry a zero popped value.
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> popped_r == '0)
    else $error("nonzero popped value on a rejected item");

  // A stalled result blocks new items.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("item taken while result is stalled");
`endif

endmodule

[dv/circular_deque_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_top_tb
// Self-checking bench for the circular deque. A clocked driver offers input
// items from a queue and predicts each accepted item's result on its own copy
// of the deque. A clocked monitor compares every result item field by field
// with the oldest prediction. Random gaps on both channels, a long receiver
// hold-off and a full drain between phases exercise the handshake.
// ----------------------------------------------------------------------------
module circular_deque_top_tb;
  import cdq_pkg::*;

  localparam int DQ_DEPTH    = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 60;
  localparam int PHASE_ITEMS = 545;
  localparam int SETTLE      = 8;

  // Burst flavors for the random part.
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_MIXED = 2;

  typedef struct {
    cdq_action_t              action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } deque_item_t;

  typedef struct {
    cdq_status_t              status;
    logic signed [DATA_W-1:0] popped;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_top #(.DEPTH(DQ_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Items waiting to be offered and results waiting to arrive.
  deque_item_t   queued_actions[$];
  deque_result_t awaited_results[$];

  // Shadow copy of the deque.
  logic signed [DATA_W-1:0] shadow_store[DQ_DEPTH];
  int shadow_head;
  int shadow_tail;
  int shadow_fill;

  int send_idle_pct;
  int recv_stall_pct;
  int items_queued;
  int items_accepted;
  int hold_requests;
  int hold_served;
  int hold_left;
  int fail_count;
  int cycle_count;

  deque_item_t offered_item;

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one item to the shadow deque and returns the result it yields.
  function automatic deque_result_t deque_step(deque_item_t it);
    deque_result_t r;
    r.status = ST_OK;
    r.popped = '0;
    case (it.action)
      ACT_PUSH_REAR: begin
        if (shadow_fill >= DQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[shadow_tail] = it.value;
          shadow_tail = (shadow_tail + 1) % DQ_DEPTH;
          shadow_fill++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (shadow_fill >= DQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DQ_DEPTH - 1) % DQ_DEPTH;
          shadow_store[shadow_head] = it.value;
          shadow_fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % DQ_DEPTH;
          shadow_fill--;
        end
      end
      ACT_POP_REAR: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_tail = (shadow_tail + DQ_DEPTH - 1) % DQ_DEPTH;
          r.popped = shadow_store[shadow_tail];
          shadow_fill--;
        end
      end
      ACT_MODIFY: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(it.position) >= shadow_fill) begin
          r.status = ST_RANGE;
        end else begin
          shadow_store[(shadow_head + int'(it.position)) % DQ_DEPTH] = it.value;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = shadow_fill[OCC_W-1:0];
    return r;
  endfunction

  // Data values lean toward the extremes now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Action mix depends on whether the burst should fill, drain or churn.
  function automatic cdq_action_t pick_action(int bias);
    int r;
    r = $urandom_range(99);
    case (bias)
      BIAS_FILL: begin
        if (r < 35)      return ACT_PUSH_REAR;
        else if (r < 70) return ACT_PUSH_FRONT;
        else if (r < 80) return ACT_POP_FRONT;
        else if (r < 90) return ACT_POP_REAR;
        else             return ACT_MODIFY;
      end
      BIAS_DRAIN: begin
        if (r < 10)      return ACT_PUSH_REAR;
        else if (r < 20) return ACT_PUSH_FRONT;
        else if (r < 50) return ACT_POP_FRONT;
        else if (r < 80) return ACT_POP_REAR;
        else             return ACT_MODIFY;
      end
      default: begin
        if (r < 20)      return ACT_PUSH_REAR;
        else if (r < 40) return ACT_PUSH_FRONT;
        else if (r < 55) return ACT_POP_FRONT;
        else if (r < 70) return ACT_POP_REAR;
        else             return ACT_MODIFY;
      end
    endcase
  endfunction

  task automatic queue_item(cdq_action_t act, logic signed [DATA_W-1:0] val,
                            logic [POS_W-1:0] pos);
    deque_item_t it;
    it.action   = act;
    it.value    = val;
    it.position = pos;
    queued_actions.push_back(it);
    items_queued++;
  endtask

  // Random bursts that swing the deque between empty and full.
  task automatic queue_random(int count);
    int made;
    int burst;
    int bias;
    made = 0;
    while (made < count) begin
      burst = $urandom_range(20, 6);
      bias  = $urandom_range(BIAS_MIXED);
      for (int i = 0; i < burst && made < count; i++) begin
        queue_item(pick_action(bias), pick_value(), POS_W'($urandom_range(POS_N - 1)));
        made++;
      end
    end
  endtask

  // Blocks new stimulus until every queued item has been answered.
  task automatic wait_drained();
    while (items_accepted != items_queued || awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: offers queued items and predicts each accepted one.
  always @(posedge clk) begin : drive_proc
    logic offer;
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.action     <= '0;
      in_if.item_value <= '0;
      in_if.position   <= '0;
      shadow_head = 0;
      shadow_tail = 0;
      shadow_fill = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        awaited_results.push_back(deque_step(offered_item));
        items_accepted++;
      end
      if (in_if.valid && !in_if.ready) begin
        offer = 1'b1;
      end else if (queued_actions.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_item = queued_actions.pop_front();
        in_if.action     <= offered_item.action;
        in_if.item_value <= offered_item.value;
        in_if.position   <= offered_item.position;
        offer = 1'b1;
      end else begin
        offer = 1'b0;
      end
      in_if.valid <= offer;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin : recv_proc
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_served != hold_requests) begin
        hold_left = LONG_HOLD;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: each accepted result item is checked against the oldest prediction.
  always @(posedge clk) begin : check_proc
    deque_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result item with no prediction: status %0d popped_value %0d occupancy %0d",
               out_if.status, out_if.popped_value, out_if.occupancy);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.popped_value !== want.popped) begin
          $error("popped_value mismatch: expected %0d, actual %0d",
                 want.popped, out_if.popped_value);
          fail_count++;
        end
        if (out_if.occupancy !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d, actual %0d",
                 want.occupancy, out_if.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    in_if.valid      = 1'b0;
    in_if.action     = '0;
    in_if.item_value = '0;
    in_if.position   = '0;
    out_if.ready     = 1'b0;
    rst_n            = 1'b0;
    send_idle_pct    = 32;
    recv_stall_pct   = 68;
    items_queued     = 0;
    items_accepted   = 0;
    hold_requests    = 0;
    hold_served      = 0;
    fail_count       = 0;
    cycle_count      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Rejections on an empty deque.
    queue_item(ACT_POP_FRONT, 32'h1234_5678, 3'd0);
    queue_item(ACT_POP_REAR, 32'h0, 3'd0);
    queue_item(ACT_MODIFY, 32'hdead_beef, 3'd0);
    // Extreme values at both ends, then offsets out of and in range.
    queue_item(ACT_PUSH_REAR, 32'h7fff_ffff, 3'd7);
    queue_item(ACT_PUSH_FRONT, 32'h8000_0000, 3'd0);
    queue_item(ACT_MODIFY, 32'h1111_1111, 3'd2);
    queue_item(ACT_MODIFY, 32'hffff_ffff, 3'd1);
    queue_item(ACT_POP_REAR, 32'h0, 3'd0);
    queue_item(ACT_PUSH_REAR, 32'h0, 3'd0);
    // Fill to capacity from both ends.
    for (int i = 0; i < 6; i++) begin
      queue_item((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_value(), 3'd0);
    end
    // Full deque: both pushes rejected, last offset writable.
    queue_item(ACT_PUSH_REAR, 32'h0bad_0bad, 3'd0);
    queue_item(ACT_PUSH_FRONT, 32'h0bad_0bad, 3'd0);
    queue_item(ACT_MODIFY, 32'ha5a5_a5a5, 3'd7);
    queue_item(ACT_POP_REAR, 32'h0, 3'd0);
    queue_item(ACT_MODIFY, 32'h5a5a_5a5a, 3'd0);
    queue_item(ACT_POP_FRONT, 32'h0, 3'd0);
    queue_item(ACT_MODIFY, 32'h2222_2222, 3'd7);

    // First random phase under the same idling.
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Second phase with the idling swapped.
    send_idle_pct  = 68;
    recv_stall_pct = 32;
    queue_random(PHASE_ITEMS);
    wait_drained();

    // Last phase with no idling and one long receiver hold-off.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(PHASE_ITEMS);
    repeat ($urandom_range(12, 4)) @(posedge clk);
    hold_requests++;
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
